// ----- rtl/core/tafg_pkg.sv -----
package tafg_pkg;

  // Vertex and coordinate geometry.
  localparam int NVERT = 4;
  localparam int NDIM  = 3;
  localparam int CW    = 32;            // Q16.16 coordinate
  localparam int DW    = CW + 1;        // half-edge, Q16.17
  localparam int PW    = 2 * DW;        // product of two half-edges
  localparam int KW    = PW + 1;        // cofactor
  localparam int KLO   = 34;            // low split of a cofactor
  localparam int KHI   = KW - KLO;      // high split of a cofactor
  localparam int LPW   = DW + KLO + 1;  // partial product with a low split
  localparam int HPW   = 2 * KHI;       // high by high partial product
  localparam int JW    = 100;           // signed determinant
  localparam int SW    = 134;           // signed metric sum
  localparam int NW    = 147;           // unsigned dividend
  localparam int DENW  = JW - 1;        // unsigned divisor (J is positive when used)
  localparam int VW    = 64;            // Q32.32 result
  localparam int QW    = VW - 1;        // quotient bits below saturation

  localparam int NDER  = 9;
  localparam int NMET  = 6;
  localparam int NDIV  = NDER + NMET;

  // Alignment shifts into Q32.32.
  localparam int DSH   = 49;
  localparam int MSH   = 15;
  localparam int JSH   = 19;

  // Cyclic neighbors for the cofactor formula.
  localparam int NXT1 [NDIM] = '{1, 2, 0};
  localparam int NXT2 [NDIM] = '{2, 0, 1};

  // Cofactor row pairs of the six metric terms rr rs rt ss st tt.
  localparam int PA [NMET] = '{0, 0, 0, 1, 1, 2};
  localparam int PB [NMET] = '{0, 1, 2, 1, 2, 2};

  localparam logic [VW-1:0] SAT_POS = {1'b0, {(VW-1){1'b1}}};
  localparam logic [VW-1:0] SAT_NEG = {1'b1, {(VW-1){1'b0}}};

  typedef struct packed {
    logic          bad;
    logic [VW-1:0] jq;
  } tafg_side_t;

  // Signed, saturated Q32.32 value from a quotient magnitude.
  function automatic logic [VW-1:0] sat_fmt(input logic neg, input logic ovf,
                                            input logic [QW-1:0] q);
    logic [VW-1:0] mag;
    mag = {1'b0, q};
    if (ovf) begin
      sat_fmt = neg ? SAT_NEG : SAT_POS;
    end else begin
      sat_fmt = neg ? (~mag + VW'(1)) : mag;
    end
  endfunction

endpackage

// ----- rtl/core/tet_affine_geometric_factors_core.sv -----
// Affine geometric factors of one tetrahedron.
// Input channel (vert_valid / vert_stall): one item carries the four vertices
// as signed Q16.16 coordinates. Output channel (res_valid / res_stall): each
// element yields two items. The first holds the nine inverse-map derivatives
// in value0..value8 and J in value9. The second, with last set, holds the six
// J-weighted metric terms in value0..value5, J in value6, zeros elsewhere.
// All values are signed Q32.32, truncated toward zero and saturated. When the
// determinant is zero or negative, bad_jacobian is set and all values are 0.
// The pipeline holds 7 stages of multiply and add, 64 divider stages (an
// overflow check, then one quotient bit per stage), and the output register.
// The second item follows in the cycle after the first is taken. As the
// single output channel carries two items per element, the input is held
// while the first item of an element is shown.
// A stall on the output freezes the whole pipeline, so nothing is lost or
// repeated; vert_stall rises while the output register cannot take a new
// element. Reset empties the pipeline and the output register.
module tet_affine_geometric_factors_core import tafg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 vert_valid,
  output logic                 vert_stall,
  input  logic signed [CW-1:0] v1_x,
  input  logic signed [CW-1:0] v1_y,
  input  logic signed [CW-1:0] v1_z,
  input  logic signed [CW-1:0] v2_x,
  input  logic signed [CW-1:0] v2_y,
  input  logic signed [CW-1:0] v2_z,
  input  logic signed [CW-1:0] v3_x,
  input  logic signed [CW-1:0] v3_y,
  input  logic signed [CW-1:0] v3_z,
  input  logic signed [CW-1:0] v4_x,
  input  logic signed [CW-1:0] v4_y,
  input  logic signed [CW-1:0] v4_z,
  output logic                 res_valid,
  input  logic                 res_stall,
  output logic                 last,
  output logic                 bad_jacobian,
  output logic signed [VW-1:0] value0,
  output logic signed [VW-1:0] value1,
  output logic signed [VW-1:0] value2,
  output logic signed [VW-1:0] value3,
  output logic signed [VW-1:0] value4,
  output logic signed [VW-1:0] value5,
  output logic signed [VW-1:0] value6,
  output logic signed [VW-1:0] value7,
  output logic signed [VW-1:0] value8,
  output logic signed [VW-1:0] value9
);

  logic [NVERT-1:0][NDIM-1:0][CW-1:0] vert;

  logic                    adv;
  logic                    fr_valid;
  tafg_side_t              fr_side;
  logic [NDIV-1:0]         fr_neg;
  logic [NDIV-1:0][NW-1:0] fr_num;
  logic [DENW-1:0]         fr_den;

  logic                    dv_valid;
  tafg_side_t              dv_side;
  logic [NDIV-1:0]         dv_neg;
  logic [NDIV-1:0]         dv_ovf;
  logic [NDIV-1:0][QW-1:0] dv_quo;

  // Output register: one element, shown as two items in turn.
  logic                    obuf_valid;
  logic                    phase;
  logic                    obuf_bad;
  logic [VW-1:0]           obuf_jq;
  logic [VW-1:0]           obuf_val [NDIV];

  assign vert = {{v4_z, v4_y, v4_x}, {v3_z, v3_y, v3_x},
                 {v2_z, v2_y, v2_x}, {v1_z, v1_y, v1_x}};

  // The pipeline moves when the output register is empty or is handing over
  // its second item this cycle.
  assign adv        = !obuf_valid || (phase && !res_stall);
  assign vert_stall = !adv;

  tafg_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (vert_valid),
    .vert      (vert),
    .out_valid (fr_valid),
    .out_side  (fr_side),
    .out_neg   (fr_neg),
    .out_num   (fr_num),
    .out_den   (fr_den)
  );

  tafg_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (fr_valid),
    .in_side   (fr_side),
    .in_neg    (fr_neg),
    .in_num    (fr_num),
    .in_den    (fr_den),
    .out_valid (dv_valid),
    .out_side  (dv_side),
    .out_neg   (dv_neg),
    .out_ovf   (dv_ovf),
    .out_quo   (dv_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      obuf_valid <= 1'b0;
      phase      <= 1'b0;
    end else if (adv) begin
      obuf_valid <= dv_valid;
      phase      <= 1'b0;
    end else if (!res_stall) begin
      phase <= 1'b1;
    end
  end

  // A bad determinant forces every value of the element to zero.
  always_ff @(posedge clk) begin
    if (adv) begin
      obuf_bad <= dv_side.bad;
      obuf_jq  <= dv_side.bad ? '0 : dv_side.jq;
      for (int l = 0; l < NDIV; l++) begin
        obuf_val[l] <= dv_side.bad ? '0 : sat_fmt(dv_neg[l], dv_ovf[l], dv_quo[l]);
      end
    end
  end

  assign res_valid    = obuf_valid;
  assign last         = phase;
  assign bad_jacobian = obuf_bad;
  assign value0 = phase ? obuf_val[NDER+0] : obuf_val[0];
  assign value1 = phase ? obuf_val[NDER+1] : obuf_val[1];
  assign value2 = phase ? obuf_val[NDER+2] : obuf_val[2];
  assign value3 = phase ? obuf_val[NDER+3] : obuf_val[3];
  assign value4 = phase ? obuf_val[NDER+4] : obuf_val[4];
  assign value5 = phase ? obuf_val[NDER+5] : obuf_val[5];
  assign value6 = phase ? obuf_jq          : obuf_val[6];
  assign value7 = phase ? '0               : obuf_val[7];
  assign value8 = phase ? '0               : obuf_val[8];
  assign value9 = phase ? '0               : obuf_jq;

endmodule

// ----- rtl/core/tafg_front.sv -----
module tafg_front import tafg_pkg::*; (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic [NVERT-1:0][NDIM-1:0][CW-1:0] vert,
  output logic                            out_valid,
  output tafg_side_t                      out_side,
  output logic [NDIV-1:0]                 out_neg,
  output logic [NDIV-1:0][NW-1:0]         out_num,
  output logic [DENW-1:0]                 out_den
);

  // Seven register stages: half-edges, cofactor products, cofactors,
  // partial products, full products, sums, then dividend preparation.
  logic [7:1] vld;

  logic signed [DW-1:0]  e1   [NDIM][NDIM];
  logic signed [PW-1:0]  pp2  [NDIM][NDIM];
  logic signed [PW-1:0]  pm2  [NDIM][NDIM];
  logic signed [DW-1:0]  e0_2 [NDIM];
  logic signed [KW-1:0]  cof3 [NDIM][NDIM];
  logic signed [DW-1:0]  e0_3 [NDIM];
  logic signed [LPW-1:0] jlo4 [NDIM];
  logic signed [HPW-1:0] jhi4 [NDIM];
  logic signed [HPW-1:0] mhh4 [NMET][NDIM];
  logic signed [LPW-1:0] mhl4 [NMET][NDIM];
  logic signed [LPW-1:0] mlh4 [NMET][NDIM];
  logic        [LPW-1:0] mll4 [NMET][NDIM];
  logic signed [KW-1:0]  cof4 [NDIM][NDIM];
  logic signed [JW-1:0]  jp5  [NDIM];
  logic signed [SW-1:0]  mp5  [NMET][NDIM];
  logic signed [KW-1:0]  cof5 [NDIM][NDIM];
  logic signed [JW-1:0]  j6;
  logic signed [SW-1:0]  s6   [NMET];
  logic signed [KW-1:0]  cof6 [NDIM][NDIM];

  logic [NDIV-1:0]         neg_c;
  logic [NDIV-1:0][NW-1:0] num_c;
  tafg_side_t              side_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[6:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NDIM; k++) begin
        for (int d = 0; d < NDIM; d++) begin
          e1[k][d] <= DW'($signed(vert[k+1][d])) - DW'($signed(vert[0][d]));
        end
      end
      for (int i = 0; i < NDIM; i++) begin
        for (int c = 0; c < NDIM; c++) begin
          pp2[i][c] <= e1[NXT1[i]][NXT1[c]] * e1[NXT2[i]][NXT2[c]];
          pm2[i][c] <= e1[NXT1[i]][NXT2[c]] * e1[NXT2[i]][NXT1[c]];
          cof3[i][c] <= KW'(pp2[i][c]) - KW'(pm2[i][c]);
        end
        e0_2[i] <= e1[0][i];
        e0_3[i] <= e0_2[i];
      end
      for (int c = 0; c < NDIM; c++) begin
        jlo4[c] <= e0_3[c] * $signed({1'b0, cof3[0][c][KLO-1:0]});
        jhi4[c] <= e0_3[c] * $signed(cof3[0][c][KW-1:KLO]);
        jp5[c]  <= (JW'(jhi4[c]) <<< KLO) + JW'(jlo4[c]);
      end
      for (int m = 0; m < NMET; m++) begin
        for (int c = 0; c < NDIM; c++) begin
          mhh4[m][c] <= $signed(cof3[PA[m]][c][KW-1:KLO]) *
                        $signed(cof3[PB[m]][c][KW-1:KLO]);
          mhl4[m][c] <= $signed(cof3[PA[m]][c][KW-1:KLO]) *
                        $signed({1'b0, cof3[PB[m]][c][KLO-1:0]});
          mlh4[m][c] <= $signed({1'b0, cof3[PA[m]][c][KLO-1:0]}) *
                        $signed(cof3[PB[m]][c][KW-1:KLO]);
          mll4[m][c] <= cof3[PA[m]][c][KLO-1:0] * cof3[PB[m]][c][KLO-1:0];
          mp5[m][c]  <= (SW'(mhh4[m][c]) <<< (2 * KLO)) + (SW'(mhl4[m][c]) <<< KLO) +
                        (SW'(mlh4[m][c]) <<< KLO) + $signed(SW'(mll4[m][c]));
        end
        s6[m] <= mp5[m][0] + mp5[m][1] + mp5[m][2];
      end
      j6   <= jp5[0] + jp5[1] + jp5[2];
      cof4 <= cof3;
      cof5 <= cof4;
      cof6 <= cof5;
    end
  end

  // Dividend magnitudes aligned to Q32.32 after division by J.
  always_comb begin
    logic [KW-1:0] magk;
    logic [SW-1:0] mags;
    for (int r = 0; r < NDIM; r++) begin
      for (int c = 0; c < NDIM; c++) begin
        neg_c[r*NDIM+c] = cof6[r][c][KW-1];
        magk = cof6[r][c][KW-1] ? KW'(-cof6[r][c]) : KW'(cof6[r][c]);
        num_c[r*NDIM+c] = NW'(magk) << DSH;
      end
    end
    for (int m = 0; m < NMET; m++) begin
      neg_c[NDER+m] = s6[m][SW-1];
      mags = s6[m][SW-1] ? SW'(-s6[m]) : SW'(s6[m]);
      num_c[NDER+m] = NW'(mags) << MSH;
    end
    side_c.bad = j6[JW-1] | (j6 == '0);
    side_c.jq  = (|j6[DENW-1:JSH+VW-1]) ? SAT_POS : VW'(j6[JSH+VW-2:JSH]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_side <= side_c;
      out_neg  <= neg_c;
      out_num  <= num_c;
      out_den  <= j6[DENW-1:0];
    end
  end

  assign out_valid = vld[7];

endmodule

// ----- rtl/core/tafg_divider.sv -----
module tafg_divider import tafg_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  tafg_side_t                in_side,
  input  logic [NDIV-1:0]           in_neg,
  input  logic [NDIV-1:0][NW-1:0]   in_num,
  input  logic [DENW-1:0]           in_den,
  output logic                      out_valid,
  output tafg_side_t                out_side,
  output logic [NDIV-1:0]           out_neg,
  output logic [NDIV-1:0]           out_ovf,
  output logic [NDIV-1:0][QW-1:0]   out_quo
);

  // Stage zero checks for a quotient beyond the saturation bound; each later
  // stage resolves one quotient bit for all lanes against the shared divisor.
  // Dividend bits shift out of nq at the top while quotient bits enter below.
  logic [QW:0]                   vld;
  logic [DENW-1:0]               den  [QW+1];
  tafg_side_t                    side [QW+1];
  logic [NDIV-1:0]               neg  [QW+1];
  logic [NDIV-1:0]               ovf  [QW+1];
  logic [NDIV-1:0][DENW-1:0]     rem  [QW+1];
  logic [NDIV-1:0][QW-1:0]       nq   [QW+1];
  logic [NDIV-1:0][DENW-1:0]     rem_n [QW];
  logic [NDIV-1:0][QW-1:0]       nq_n  [QW];

  always_comb begin
    logic [DENW:0] t;
    logic [DENW:0] d;
    logic          ge;
    for (int k = 1; k <= QW; k++) begin
      for (int l = 0; l < NDIV; l++) begin
        t  = {rem[k-1][l], nq[k-1][l][QW-1]};
        d  = {1'b0, den[k-1]};
        ge = (t >= d);
        rem_n[k-1][l] = ge ? DENW'(t - d) : DENW'(t);
        nq_n[k-1][l]  = {nq[k-1][l][QW-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[QW-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den[0]  <= in_den;
      side[0] <= in_side;
      neg[0]  <= in_neg;
      for (int l = 0; l < NDIV; l++) begin
        ovf[0][l] <= ((NW + QW)'(in_num[l]) >= {in_den, QW'(0)});
        rem[0][l] <= DENW'(in_num[l][NW-1:QW]);
        nq[0][l]  <= in_num[l][QW-1:0];
      end
      for (int k = 1; k <= QW; k++) begin
        den[k]  <= den[k-1];
        side[k] <= side[k-1];
        neg[k]  <= neg[k-1];
        ovf[k]  <= ovf[k-1];
        rem[k]  <= rem_n[k-1];
        nq[k]   <= nq_n[k-1];
      end
    end
  end

  assign out_valid = vld[QW];
  assign out_side  = side[QW];
  assign out_neg   = neg[QW];
  assign out_ovf   = ovf[QW];
  assign out_quo   = nq[QW];

endmodule

// ----- rtl/core/tafg_checker.sv -----
module tafg_checker import tafg_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 res_valid,
  input logic                 res_stall,
  input logic                 last,
  input logic                 bad_jacobian,
  input logic signed [VW-1:0] value0,
  input logic signed [VW-1:0] value6,
  input logic signed [VW-1:0] value7,
  input logic signed [VW-1:0] value8,
  input logic signed [VW-1:0] value9
);

  // The metric item follows the derivative item at once.
  a_pair: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_stall && !last) |=> (res_valid && last))
    else $error("metric item did not follow the derivative item");

  // Both items of an element carry the same determinant.
  a_det: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_stall && !last) |=>
      (value6 == $past(value9) && bad_jacobian == $past(bad_jacobian)))
    else $error("determinant differs between the two items of an element");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && bad_jacobian) |-> (value0 == '0 && value6 == '0 && value9 == '0))
    else $error("nonzero value with a bad determinant");

  a_tail_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && last) |-> (value7 == '0 && value8 == '0 && value9 == '0))
    else $error("unused fields of the metric item are not zero");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> (res_valid && $stable(last) && $stable(value0)))
    else $error("stalled item changed");

endmodule

bind tet_affine_geometric_factors_core tafg_checker u_tafg_checker (
  .clk          (clk),
  .rst          (rst),
  .res_valid    (res_valid),
  .res_stall    (res_stall),
  .last         (last),
  .bad_jacobian (bad_jacobian),
  .value0       (value0),
  .value6       (value6),
  .value7       (value7),
  .value8       (value8),
  .value9       (value9)
);
